FILE: hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHECK_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`define CHECK_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/sckm_pkg.sv
package sckm_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int SLOT_BITS     = 10;
    localparam int USED_BITS     = SLOT_BITS + 1;
    localparam int KEY_BITS      = 48;
    localparam int ROW_BITS      = 16;
    localparam int COUNT_BITS    = ROW_BITS + 1;
    localparam int MAX_DIMS      = 4;
    localparam int COORD_BITS    = 16;
    localparam int STRIDE_BITS   = 32;
    localparam int SUM_BITS      = 50;
    localparam int HASH_SHIFT    = 29;
    localparam int HASH_BITS     = HASH_SHIFT + SLOT_BITS;
    localparam int HALF_BITS     = 20;
    localparam int ENTRY_BITS    = 1 + KEY_BITS + ROW_BITS;
    localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_TOO_LARGE = 2'd2;
    localparam logic [1:0] STS_ROWS_OUT  = 2'd3;

    localparam logic [2:0] CFG_DIMS     = 3'd0;
    localparam logic [2:0] CFG_STRIDE_0 = 3'd1;
    localparam logic [2:0] CFG_STRIDE_1 = 3'd2;
    localparam logic [2:0] CFG_STRIDE_2 = 3'd3;
    localparam logic [2:0] CFG_STRIDE_3 = 3'd4;

    typedef struct packed {
        logic       load_in;
        logic       acc_clr;
        logic       acc_add;
        logic [1:0] dim_sel;
        logic       hash_add;
        logic [1:0] hash_sel;
        logic       probe_init;
        logic       mem_rd;
        logic       probe_adv;
        logic       sweep_clr;
        logic       sweep_wr;
        logic       wipe;
        logic       res_clr;
        logic       res_status_en;
        logic [1:0] res_status;
        logic       row_take;
        logic       ins_hit;
        logic       ins_new;
        logic       q_hit;
        logic       out_load;
    } sckm_cmd_t;

    typedef struct packed {
        logic [2:0] nd;
        logic       too_large;
        logic       row_exh;
        logic       rd_valid;
        logic       rd_match;
        logic       probe_last;
        logic       table_full;
        logic       sweep_last;
    } sckm_stat_t;

endpackage

FILE: hw/rtl/sckm_datapath.sv
module sckm_datapath
    import sckm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [STRIDE_BITS-1:0] cfg_data,
    input  logic [COORD_BITS-1:0]  coord_zero,
    input  logic [COORD_BITS-1:0]  coord_one,
    input  logic [COORD_BITS-1:0]  coord_two,
    input  logic [COORD_BITS-1:0]  coord_three,
    input  sckm_cmd_t              cmd,
    output sckm_stat_t             stat,
    output logic                   found,
    output logic [ROW_BITS-1:0]    source_row,
    output logic [1:0]             status
);

    logic [2:0]             dims_reg;
    logic [STRIDE_BITS-1:0] stride_reg [MAX_DIMS];
    logic [COORD_BITS-1:0]  coord_reg [MAX_DIMS];
    logic [SUM_BITS-1:0]    acc_reg;
    logic [HASH_BITS-1:0]   hash_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [SLOT_BITS:0]     probe_cnt_reg;
    logic [SLOT_BITS-1:0]   sweep_addr_reg;
    logic [COUNT_BITS-1:0]  insert_count_reg;
    logic [USED_BITS-1:0]   used_reg;
    logic                   res_found_reg;
    logic [ROW_BITS-1:0]    res_row_reg;
    logic [1:0]             res_status_reg;
    logic                   out_found_reg;
    logic [ROW_BITS-1:0]    out_row_reg;
    logic [1:0]             out_status_reg;
    logic [ENTRY_BITS-1:0]  mem [TABLE_ENTRIES];
    logic [ENTRY_BITS-1:0]  rd_reg;

    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            prod;
    logic [HASH_BITS-1:0]   hash_term;
    logic [SLOT_BITS-1:0]   home_slot;
    logic [KEY_BITS-1:0]    key;
    logic                   mem_we;
    logic [SLOT_BITS-1:0]   mem_wa;
    logic [ENTRY_BITS-1:0]  mem_wd;
    logic [2:0]             nd_sat;

    assign key = acc_reg[KEY_BITS-1:0];

    always_comb
    begin
        if (cmd.hash_add)
        begin
            case (cmd.hash_sel)
                2'd0:
                begin
                    mul_a = 32'(key[HALF_BITS-1:0]);
                    mul_b = 32'(HASH_MULT[HALF_BITS-1:0]);
                end
                2'd1:
                begin
                    mul_a = 32'(key[HALF_BITS-1:0]);
                    mul_b = 32'(HASH_MULT[HASH_BITS-1:HALF_BITS]);
                end
                default:
                begin
                    mul_a = 32'(key[HASH_BITS-1:HALF_BITS]);
                    mul_b = 32'(HASH_MULT[HALF_BITS-1:0]);
                end
            endcase
        end
        else
        begin
            mul_a = 32'(coord_reg[cmd.dim_sel]);
            mul_b = stride_reg[cmd.dim_sel];
        end
    end

    assign prod = 64'(mul_a) * 64'(mul_b);
    assign hash_term = (cmd.hash_sel == 2'd0) ? prod[HASH_BITS-1:0]
                     : {prod[HASH_BITS-HALF_BITS-1:0], {HALF_BITS{1'b0}}};
    assign home_slot = hash_reg[SLOT_BITS-1:0] ^ hash_reg[HASH_BITS-1:HASH_SHIFT];

    assign mem_we = cmd.sweep_wr | cmd.ins_hit | cmd.ins_new;
    assign mem_wa = cmd.sweep_wr ? sweep_addr_reg : slot_reg;
    assign mem_wd = cmd.sweep_wr ? '0 : {1'b1, key, res_row_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.mem_rd)
        begin
            rd_reg <= mem[slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg         <= 3'd1;
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                stride_reg[i] <= '0;
            end
            sweep_addr_reg   <= '0;
            insert_count_reg <= '0;
            used_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIMS:     dims_reg      <= cfg_data[2:0];
                    CFG_STRIDE_0: stride_reg[0] <= cfg_data;
                    CFG_STRIDE_1: stride_reg[1] <= cfg_data;
                    CFG_STRIDE_2: stride_reg[2] <= cfg_data;
                    CFG_STRIDE_3: stride_reg[3] <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.sweep_clr)
            begin
                sweep_addr_reg <= '0;
            end
            else if (cmd.sweep_wr)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
            if (cmd.wipe)
            begin
                insert_count_reg <= '0;
                used_reg         <= '0;
            end
            else
            begin
                if (cmd.row_take)
                begin
                    insert_count_reg <= insert_count_reg + 1'b1;
                end
                if (cmd.ins_new)
                begin
                    used_reg <= used_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            coord_reg[0] <= coord_zero;
            coord_reg[1] <= coord_one;
            coord_reg[2] <= coord_two;
            coord_reg[3] <= coord_three;
        end
        if (cmd.acc_clr)
        begin
            acc_reg  <= '0;
            hash_reg <= '0;
        end
        else
        begin
            if (cmd.acc_add)
            begin
                acc_reg <= acc_reg + SUM_BITS'(prod[COORD_BITS+STRIDE_BITS-1:0]);
            end
            if (cmd.hash_add)
            begin
                hash_reg <= hash_reg + hash_term;
            end
        end
        if (cmd.probe_init)
        begin
            slot_reg      <= home_slot;
            probe_cnt_reg <= '0;
        end
        else if (cmd.probe_adv)
        begin
            slot_reg      <= slot_reg + 1'b1;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
        if (cmd.res_clr)
        begin
            res_found_reg  <= 1'b0;
            res_row_reg    <= '0;
            res_status_reg <= STS_OK;
        end
        else
        begin
            if (cmd.res_status_en)
            begin
                res_status_reg <= cmd.res_status;
            end
            if (cmd.row_take)
            begin
                res_row_reg <= insert_count_reg[ROW_BITS-1:0];
            end
            if (cmd.q_hit)
            begin
                res_found_reg <= 1'b1;
                res_row_reg   <= rd_reg[ROW_BITS-1:0];
            end
        end
        if (cmd.out_load)
        begin
            out_found_reg  <= res_found_reg;
            out_row_reg    <= res_row_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        if (dims_reg == 3'd0)
        begin
            nd_sat = 3'd1;
        end
        else if (dims_reg > 3'(MAX_DIMS))
        begin
            nd_sat = 3'(MAX_DIMS);
        end
        else
        begin
            nd_sat = dims_reg;
        end
    end

    assign stat.nd         = nd_sat;
    assign stat.too_large  = |acc_reg[SUM_BITS-1:KEY_BITS];
    assign stat.row_exh    = insert_count_reg[ROW_BITS];
    assign stat.rd_valid   = rd_reg[ENTRY_BITS-1];
    assign stat.rd_match   = rd_reg[ENTRY_BITS-2:ROW_BITS] == key;
    assign stat.probe_last = probe_cnt_reg == (SLOT_BITS+1)'(TABLE_ENTRIES - 1);
    assign stat.table_full = used_reg >= USED_BITS'(TABLE_ENTRIES);
    assign stat.sweep_last = &sweep_addr_reg;

    assign found      = out_found_reg;
    assign source_row = out_row_reg;
    assign status     = out_status_reg;

endmodule

FILE: hw/rtl/sckm_controller.sv
`include "assert_macros.svh"

module sckm_controller
    import sckm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output sckm_cmd_t  cmd,
    input  sckm_stat_t stat
);

    localparam logic [3:0] S_SWEEP    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_KEY      = 4'd2;
    localparam logic [3:0] S_CHECK    = 4'd3;
    localparam logic [3:0] S_HASH     = 4'd4;
    localparam logic [3:0] S_PINIT    = 4'd5;
    localparam logic [3:0] S_PROBE_RD = 4'd6;
    localparam logic [3:0] S_PROBE_CK = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [1:0] dim_cnt_reg, dim_cnt_next;
    logic [1:0] hash_cnt_reg, hash_cnt_next;
    logic       from_op_reg, from_op_next;
    logic       out_valid_reg, out_valid_next;
    logic       insert;

    assign insert    = op_reg == OP_INSERT;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        dim_cnt_next  = dim_cnt_reg;
        hash_cnt_next = hash_cnt_reg;
        from_op_next  = from_op_reg;
        cmd           = '0;
        cmd.dim_sel   = dim_cnt_reg;
        cmd.hash_sel  = hash_cnt_reg;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = from_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in  = 1'b1;
                    cmd.acc_clr  = 1'b1;
                    cmd.res_clr  = 1'b1;
                    op_next      = in_op;
                    dim_cnt_next = '0;
                    case (in_op)
                        OP_CLEAR:
                        begin
                            cmd.wipe      = 1'b1;
                            cmd.sweep_clr = 1'b1;
                            from_op_next  = 1'b1;
                            state_next    = S_SWEEP;
                        end
                        OP_INSERT, OP_QUERY:
                        begin
                            state_next = S_KEY;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_KEY:
            begin
                cmd.acc_add  = 1'b1;
                dim_cnt_next = dim_cnt_reg + 1'b1;
                if ({1'b0, dim_cnt_reg} + 3'd1 == stat.nd)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                hash_cnt_next = '0;
                if (insert && stat.row_exh)
                begin
                    cmd.res_status_en = 1'b1;
                    cmd.res_status    = STS_ROWS_OUT;
                    state_next        = S_DONE;
                end
                else
                begin
                    cmd.row_take = insert;
                    if (stat.too_large)
                    begin
                        cmd.res_status_en = 1'b1;
                        cmd.res_status    = STS_TOO_LARGE;
                        state_next        = S_DONE;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                cmd.hash_add  = 1'b1;
                hash_cnt_next = hash_cnt_reg + 1'b1;
                if (hash_cnt_reg == 2'd2)
                begin
                    state_next = S_PINIT;
                end
            end
            S_PINIT:
            begin
                cmd.probe_init = 1'b1;
                state_next     = S_PROBE_RD;
            end
            S_PROBE_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_PROBE_CK;
            end
            S_PROBE_CK:
            begin
                state_next = S_DONE;
                if (!stat.rd_valid)
                begin
                    if (insert)
                    begin
                        if (stat.table_full)
                        begin
                            cmd.res_status_en = 1'b1;
                            cmd.res_status    = STS_FULL;
                        end
                        else
                        begin
                            cmd.ins_new = 1'b1;
                        end
                    end
                end
                else if (stat.rd_match)
                begin
                    cmd.ins_hit = insert;
                    cmd.q_hit   = !insert;
                end
                else if (stat.probe_last)
                begin
                    if (insert)
                    begin
                        cmd.res_status_en = 1'b1;
                        cmd.res_status    = STS_FULL;
                    end
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = S_PROBE_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            op_reg        <= OP_CLEAR;
            dim_cnt_reg   <= '0;
            hash_cnt_reg  <= '0;
            from_op_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            dim_cnt_reg   <= dim_cnt_next;
            hash_cnt_reg  <= hash_cnt_next;
            from_op_reg   <= from_op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CHECK_IMPLY(a_no_overwrite, cmd.out_load && out_valid_reg, out_ready, "result overwritten")
    `CHECK_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word taken while busy")
    `CHECK_IMPLY(a_new_not_full, cmd.ins_new, !stat.table_full, "insert into full table")
    `CHECK_IMPLY(a_check_after_read, state_reg == S_PROBE_CK, $past(cmd.mem_rd), "probe without read")

endmodule

FILE: hw/rtl/sparse_coordinate_key_match_unit.sv
// Sparse coordinate key match: flattens up to four 16-bit coordinates into a key
// (sum of coordinate times stride, one multiply per cycle) and inserts or looks it up
// in a 1024-entry open-addressed hash table with linear probing in one
// single-port-read memory. One word is processed at a time: an insert or query
// visits probe slots from the hashed home slot, one memory read each; a failed
// insert can visit every slot. After reset and on every clear word the table is
// wiped by a sweep that clears every entry, during which no input word is taken;
// configuration writes are taken at any time. One result word is returned per
// input word and is held in an output register, so the next input may be taken
// while it waits.
module sparse_coordinate_key_match_unit
    import sckm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], coord_zero[17:2], coord_one[33:18], coord_two[49:34],
    // coord_three[65:50], zero fill
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found[0], source_row[16:1], status[18:17], zero fill
    output logic [23:0] m_axis_tdata
);

    sckm_cmd_t           cmd;
    sckm_stat_t          stat;
    logic                found;
    logic [ROW_BITS-1:0] source_row;
    logic [1:0]          status;

    sckm_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tdata[1:0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sckm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .coord_zero  (s_axis_tdata[17:2]),
        .coord_one   (s_axis_tdata[33:18]),
        .coord_two   (s_axis_tdata[49:34]),
        .coord_three (s_axis_tdata[65:50]),
        .cmd         (cmd),
        .stat        (stat),
        .found       (found),
        .source_row  (source_row),
        .status      (status)
    );

    assign m_axis_tdata = {5'b0, status, source_row, found};

endmodule
